// ===== hw/rtl/sha_pkg.sv =====
// sha256 stream hasher package: round constants, initial hash, helper functions
// no dependencies
package sha_pkg;

   localparam int unsigned BlockWords = 16;
   localparam int unsigned Rounds     = 64;
   localparam int unsigned WordIdxW   = $clog2(BlockWords);

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef struct packed {
      logic start;
      logic busy;
   } comp_ctl_type;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
      ror32 = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] small_sig0(input logic [31:0] x);
      small_sig0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sig1(input logic [31:0] x);
      small_sig1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] big_sig0(input logic [31:0] x);
      big_sig0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
   endfunction

   function automatic logic [31:0] big_sig1(input logic [31:0] x);
      big_sig1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
   endfunction

endpackage

// ===== hw/rtl/sha256_stream_hasher.sv =====
// sha256 stream hasher top: byte packing, padding sequencer and digest output
// depends on sha_core, which uses sha_pkg and sha_ram
// input: a byte that does not fill a block is accepted while idle; a block-filling
// byte stalls the input while the core runs its prime, round and add steps
// end of message: the pad words are written, then each padded block is compressed
// (two blocks when 56 or more bytes are held), then the eight digest words are sent
// synchronous active-high reset restores the initial hash, zero count and idle state
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_COMP  = 3'd1;
   localparam logic [2:0] ST_PAD   = 3'd2;
   localparam logic [2:0] ST_PCOMP = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [23:0] part_ff, part_in;
   logic [63:0] total_ff, total_in;
   logic        two_ff, two_in;
   logic        eom_ff, eom_in;
   logic [3:0]  pw_ff, pw_in;
   logic [2:0]  oi_ff, oi_in;
   logic        started_ff, started_in;

   logic                         wr_en, start, init_chain, busy;
   logic [3:0]                   wr_addr;
   logic [31:0]                  wr_data, pad_word;
   logic [31:0]                  chain_word [8];
   logic [31:0]                  cur_word;
   logic [6:0]                   fill_next;
   logic                         accept;

   sha_core u_core (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .init_chain (init_chain),
      .ld_wr_en   (wr_en),
      .ld_wr_addr (wr_addr),
      .ld_wr_data (wr_data),
      .busy       (busy),
      .chain_word (chain_word)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign fill_next = {1'b0, fill_ff} + 7'd1;
   assign cur_word  = {part_ff, req_data_byte};

   // padding word pw_ff of the final block(s); fill_ff holds the byte count before padding
   always_comb begin
      logic [5:0]  base;
      logic [23:0] part_al;
      base = {pw_ff, 2'b00};
      part_al = part_ff << {2'd3 - fill_ff[1:0], 3'b000};
      pad_word = '0;
      if (two_ff && pw_ff == 4'd15 && eom_ff) begin
         pad_word = total_ff[31:0];
      end else if (two_ff && pw_ff == 4'd14 && eom_ff) begin
         pad_word = total_ff[63:32];
      end else if (!two_ff && pw_ff == 4'd15) begin
         pad_word = total_ff[31:0];
      end else if (!two_ff && pw_ff == 4'd14) begin
         pad_word = total_ff[63:32];
      end
      for (int b = 0; b < 4; b++) begin
         if (!(two_ff && eom_ff) && 6'(base + 6'(b)) == fill_ff
             && !(!two_ff && pw_ff >= 4'd14)) begin
            pad_word[31 - 8*b -: 8] = 8'h80;
         end else if (!(two_ff && eom_ff) && 6'(base + 6'(b)) < fill_ff) begin
            case (b)
               0: pad_word[31:24] = part_al[23:16];
               1: pad_word[23:16] = part_al[15:8];
               2: pad_word[15:8]  = part_al[7:0];
               default: pad_word[7:0] = 8'h00;
            endcase
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      bits_in    = bits_ff;
      part_in    = part_ff;
      total_in   = total_ff;
      two_in     = two_ff;
      eom_in     = eom_ff;
      pw_in      = pw_ff;
      oi_in      = oi_ff;
      started_in = started_ff;
      wr_en      = 1'b0;
      wr_addr    = fill_ff[5:2];
      wr_data    = cur_word;
      start      = 1'b0;
      init_chain = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_byte_valid) begin
                  part_in = {part_ff[15:0], req_data_byte};
                  wr_en   = (fill_ff[1:0] == 2'd3);
                  fill_in = fill_next[5:0];
                  if (fill_next[6]) begin
                     start      = 1'b1;
                     started_in = 1'b0;
                     bits_in    = bits_ff + 64'd512;
                     eom_in     = req_end_of_message;
                     state_in   = ST_COMP;
                  end else if (req_end_of_message) begin
                     state_in = ST_PAD;
                  end
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
               if (req_end_of_message && !(req_byte_valid && fill_next[6])) begin
                  total_in = bits_ff + {55'd0, (req_byte_valid ? fill_next[5:0] : fill_ff), 3'd0};
                  fill_in  = req_byte_valid ? fill_next[5:0] : fill_ff;
                  two_in   = ((req_byte_valid ? fill_next[5:0] : fill_ff) >= 6'd56);
                  eom_in   = 1'b0;
                  pw_in    = (req_byte_valid ? fill_next[5:2] : fill_ff[5:2]);
                  if (req_byte_valid && fill_next[1:0] == 2'd0) begin
                     part_in = '0;
                  end
               end
            end
         end
         ST_COMP: begin
            if (!busy && started_ff) begin
               state_in = ST_IDLE;
               if (eom_ff) begin
                  total_in = bits_ff;
                  two_in   = 1'b0;
                  eom_in   = 1'b0;
                  fill_in  = '0;
                  pw_in    = '0;
                  state_in = ST_PAD;
               end
            end
            started_in = 1'b1;
         end
         ST_PAD: begin
            wr_en   = 1'b1;
            wr_addr = pw_ff;
            wr_data = pad_word;
            pw_in   = pw_ff + 4'd1;
            if (pw_ff == 4'd15) begin
               start      = 1'b1;
               started_in = 1'b0;
               state_in   = ST_PCOMP;
            end
         end
         ST_PCOMP: begin
            started_in = 1'b1;
            if (!busy && started_ff) begin
               if (two_ff && !eom_ff) begin
                  eom_in   = 1'b1;
                  pw_in    = '0;
                  state_in = ST_PAD;
               end else begin
                  oi_in    = '0;
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               oi_in = oi_ff + 3'd1;
               if (oi_ff == 3'd7) begin
                  init_chain = 1'b1;
                  fill_in    = '0;
                  bits_in    = '0;
                  part_in    = '0;
                  eom_in     = 1'b0;
                  two_in     = 1'b0;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fill_ff    <= '0;
         bits_ff    <= '0;
         part_ff    <= '0;
         two_ff     <= 1'b0;
         eom_ff     <= 1'b0;
         pw_ff      <= '0;
         oi_ff      <= '0;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         bits_ff    <= bits_in;
         part_ff    <= part_in;
         two_ff     <= two_in;
         eom_ff     <= eom_in;
         pw_ff      <= pw_in;
         oi_ff      <= oi_in;
         started_ff <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
   end

   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = chain_word[oi_ff];
   assign rsp_word_index  = oi_ff;
   assign rsp_last_word   = (oi_ff == 3'd7);

endmodule

// ===== hw/rtl/sha_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module sha_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/sha_core.sv =====
// sha256 compression engine: one round per cycle; block words in a ram, schedule in registers
// depends on sha_pkg and sha_ram
module sha_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            init_chain,
   // block word ram write side, owned by the loader while idle; the core itself does not enforce this
   input  logic                            ld_wr_en,
   input  logic [sha_pkg::WordIdxW-1:0]    ld_wr_addr,
   input  logic [31:0]                     ld_wr_data,
   output logic                            busy,
   output logic [31:0]                     chain_word [8]
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PRIME = 2'd1;
   localparam logic [1:0] ST_ROUND = 2'd2;
   localparam logic [1:0] ST_ADD   = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [6:0]  rnd_ff, rnd_in;
   logic [31:0] h_ff [8];
   logic [31:0] v_ff [8];
   logic [31:0] win_ff [16];

   logic                         ram_we;
   logic [sha_pkg::WordIdxW-1:0] ram_waddr, ram_raddr;
   logic [31:0]                  ram_wdata, ram_rdata;
   logic [31:0]                  w_cur, w_new, t1, t2;
   logic [5:0]                   rnd6;

   sha_ram #(.Width(32), .Depth(sha_pkg::BlockWords)) u_wram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign rnd6  = rnd_ff[5:0];
   assign w_new = sha_pkg::small_sig1(win_ff[14]) + win_ff[9]
                + sha_pkg::small_sig0(win_ff[1]) + win_ff[0];
   assign w_cur = (rnd_ff < 7'd16) ? ram_rdata : w_new;
   assign t1 = v_ff[7] + sha_pkg::big_sig1(v_ff[4])
             + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + sha_pkg::ROUND_K[rnd6] + w_cur;
   assign t2 = sha_pkg::big_sig0(v_ff[0])
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   always_comb begin
      ram_we    = ld_wr_en;
      ram_waddr = ld_wr_addr;
      ram_wdata = ld_wr_data;
      ram_raddr = (state_ff == ST_ROUND) ? 4'(rnd_ff + 7'd1) : '0;
      state_in  = state_ff;
      rnd_in    = rnd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_PRIME;
               rnd_in   = '0;
            end
         end
         ST_PRIME: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == 7'(sha_pkg::Rounds - 1)) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || init_chain) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= sha_pkg::INIT_HASH[i];
      end else if (state_ff == ST_ADD) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_PRIME) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      end else if (state_ff == ST_ROUND) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
         for (int i = 0; i < 15; i++) win_ff[i] <= win_ff[i + 1];
         win_ff[15] <= w_cur;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   always_comb begin
      for (int i = 0; i < 8; i++) chain_word[i] = h_ff[i];
   end

endmodule
